FILE: hdl/pd_sink_pdo_selector_core_defines.svh
// Assertion macros of the PDO selector, used by the tracker module.
`ifndef PD_SINK_PDO_SELECTOR_CORE_DEFINES_SVH
`define PD_SINK_PDO_SELECTOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

`define PDS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pdsel assertion failed");

`define PDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdsel assertion failed");

`else

`define PDS_ASSERT(lbl, clk, rst_n, prop)

`define PDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/pdsel_pkg.sv
// Types, constants and helper functions of the PDO selector.
`timescale 1ns / 1ps

package pdsel_pkg;

    localparam int unsigned MAX_PDOS = 7;

    localparam logic [1:0]  PDO_TYPE_FIXED = 2'b00;
    localparam logic [15:0] SAFE_MV        = 16'd5000;

    localparam logic        RST_NEED_MODE  = 1'b0;
    localparam logic [13:0] RST_BOARD_MA   = 14'd500;
    localparam logic [13:0] RST_LOOP_MA    = 14'd0;
    localparam logic [15:0] RST_PREF_MV    = 16'd5000;
    localparam logic [15:0] RST_SPR_MV     = 16'd20000;
    localparam logic [13:0] RST_RDO_MAX_MA = 14'd3000;
    localparam logic        RST_GIVEBACK   = 1'b0;

    typedef enum logic [2:0] {
        CFG_NEED_MODE  = 3'd0,
        CFG_BOARD_MA   = 3'd1,
        CFG_LOOP_MA    = 3'd2,
        CFG_PREF_MV    = 3'd3,
        CFG_SPR_MV     = 3'd4,
        CFG_RDO_MAX_MA = 3'd5,
        CFG_GIVEBACK   = 3'd6
    } pdsel_cfg_idx_t;

    typedef enum logic [1:0] {
        RES_MATCH    = 2'd0,
        RES_FALLBACK = 2'd1,
        RES_NONE     = 2'd2,
        RES_INVALID  = 2'd3
    } pdsel_code_t;

    typedef struct packed {
        logic        need_mode;
        logic [13:0] board_ma;
        logic [13:0] loop_ma;
        logic [15:0] pref_mv;
        logic [15:0] spr_mv;
        logic [13:0] rdo_max_ma;
        logic        giveback;
    } pdsel_cfg_t;

    typedef struct packed {
        logic        vld;
        logic        last;
        logic        fixed;
        logic [15:0] mv;
        logic [13:0] ma;
    } pdsel_word_t;

    // Exact divide by ten for every 15-bit value, low ten bits of the quotient.
    function automatic logic [9:0] div10_lo(input logic [14:0] x);
        logic [31:0] prod;
        prod = 32'(x) * 32'd52429;
        return prod[28:19];
    endfunction

endpackage

FILE: hdl/pdsel_cfg.sv
// Configuration register file of the PDO selector.
`timescale 1ns / 1ps

module pdsel_cfg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    output pdsel_pkg::pdsel_cfg_t cfg
);
    import pdsel_pkg::*;

    pdsel_cfg_t cfg_reg;
    pdsel_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (pdsel_cfg_idx_t'(cfg_index))
                CFG_NEED_MODE:  cfg_next.need_mode  = cfg_data[0];
                CFG_BOARD_MA:   cfg_next.board_ma   = cfg_data[13:0];
                CFG_LOOP_MA:    cfg_next.loop_ma    = cfg_data[13:0];
                CFG_PREF_MV:    cfg_next.pref_mv    = cfg_data;
                CFG_SPR_MV:     cfg_next.spr_mv     = cfg_data;
                CFG_RDO_MAX_MA: cfg_next.rdo_max_ma = cfg_data[13:0];
                CFG_GIVEBACK:   cfg_next.giveback   = cfg_data[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.need_mode  <= RST_NEED_MODE;
            cfg_reg.board_ma   <= RST_BOARD_MA;
            cfg_reg.loop_ma    <= RST_LOOP_MA;
            cfg_reg.pref_mv    <= RST_PREF_MV;
            cfg_reg.spr_mv     <= RST_SPR_MV;
            cfg_reg.rdo_max_ma <= RST_RDO_MAX_MA;
            cfg_reg.giveback   <= RST_GIVEBACK;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hdl/pdsel_decode.sv
// Input register and PDO word decode stage of the PDO selector.
`timescale 1ns / 1ps

module pdsel_decode (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [31:0]            raw_pdo,
    input  logic                   last_item,
    input  logic                   take,
    output pdsel_pkg::pdsel_word_t word
);
    import pdsel_pkg::*;

    logic        s1_vld_reg;
    logic        s1_vld_next;
    logic [31:0] s1_raw_reg;
    logic        s1_last_reg;
    logic        s2_vld_reg;
    logic        s2_vld_next;
    logic        s2_last_reg;
    logic        s2_fixed_reg;
    logic [15:0] s2_mv_reg;
    logic [13:0] s2_ma_reg;
    logic        fixed;
    logic [15:0] mv;
    logic [13:0] ma;

    assign in_ready = !s1_vld_reg || take;

    always_comb
    begin
        fixed = (s1_raw_reg[31:30] == PDO_TYPE_FIXED);
        mv = '0;
        ma = '0;
        if (fixed)
        begin
            mv = 16'(s1_raw_reg[19:10]) * 16'd50;
            ma = 14'(s1_raw_reg[9:0]) * 14'd10;
        end
    end

    always_comb
    begin
        s1_vld_next = s1_vld_reg;
        if (in_ready)
        begin
            s1_vld_next = in_valid;
        end
        s2_vld_next = s2_vld_reg;
        if (take)
        begin
            s2_vld_next = s1_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_raw_reg  <= raw_pdo;
            s1_last_reg <= last_item;
        end
        if (take && s1_vld_reg)
        begin
            s2_last_reg  <= s1_last_reg;
            s2_fixed_reg <= fixed;
            s2_mv_reg    <= mv;
            s2_ma_reg    <= ma;
        end
    end

    assign word = '{vld: s2_vld_reg, last: s2_last_reg, fixed: s2_fixed_reg,
                    mv: s2_mv_reg, ma: s2_ma_reg};

endmodule

FILE: hdl/pdsel_track.sv
// Running best-PDO tracker and result register of the PDO selector.
`timescale 1ns / 1ps
`include "pd_sink_pdo_selector_core_defines.svh"

module pdsel_track #(
    parameter int unsigned MAX_PDO_COUNT = pdsel_pkg::MAX_PDOS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pdsel_pkg::pdsel_cfg_t  cfg,
    input  pdsel_pkg::pdsel_word_t word,
    output logic                   take,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             result_code,
    output logic [3:0]             chosen_position,
    output logic [15:0]            contract_mv,
    output logic [14:0]            request_ma,
    output logic                   mismatch,
    output logic [31:0]            request_word
);
    import pdsel_pkg::*;

    logic [3:0]  count_reg,      count_next;
    logic        first_bad_reg,  first_bad_next;
    logic        best_vld_reg,   best_vld_next;
    logic [3:0]  best_pos_reg,   best_pos_next;
    logic [15:0] best_mv_reg,    best_mv_next;
    logic [13:0] best_ma_reg,    best_ma_next;
    logic        five_vld_reg,   five_vld_next;
    logic [3:0]  five_pos_reg,   five_pos_next;
    logic [13:0] five_ma_reg,    five_ma_next;

    logic        res_vld_reg,    res_vld_next;
    pdsel_code_t res_code_reg,   res_code_next;
    logic [3:0]  res_pos_reg,    res_pos_next;
    logic [15:0] res_mv_reg,     res_mv_next;
    logic [14:0] res_ma_reg,     res_ma_next;
    logic        res_mis_reg,    res_mis_next;
    logic [31:0] res_word_reg,   res_word_next;

    logic        consume;
    logic        finish;
    logic        live;
    logic        is_safe;
    logic        usable;
    logic        better;
    logic [3:0]  pos;
    logic [14:0] need;
    logic [15:0] target;

    assign take    = !word.vld || !word.last || !res_vld_reg || out_ready;
    assign consume = word.vld && take;
    assign finish  = consume && word.last;

    always_comb
    begin
        need   = 15'(cfg.board_ma) + (cfg.need_mode ? 15'(cfg.loop_ma) : 15'd0);
        target = cfg.need_mode ? cfg.pref_mv : SAFE_MV;
        if (target > cfg.spr_mv)
        begin
            target = cfg.spr_mv;
        end
        live    = (count_reg < 4'(MAX_PDO_COUNT));
        pos     = count_reg + 4'd1;
        is_safe = word.fixed && (word.mv == SAFE_MV);
        usable  = live && word.fixed && (word.mv != 16'd0) && (word.mv <= cfg.spr_mv)
                  && (15'(word.ma) >= need) && (word.mv <= target);
        better  = !best_vld_reg || (word.mv > best_mv_reg)
                  || ((word.mv == best_mv_reg) && (word.ma > best_ma_reg));

        count_next     = (count_reg == 4'd15) ? count_reg : count_reg + 4'd1;
        first_bad_next = first_bad_reg || (live && (count_reg == 4'd0) && !is_safe);
        five_vld_next  = five_vld_reg;
        five_pos_next  = five_pos_reg;
        five_ma_next   = five_ma_reg;
        if (live && is_safe && !five_vld_reg)
        begin
            five_vld_next = 1'b1;
            five_pos_next = pos;
            five_ma_next  = word.ma;
        end
        best_vld_next = best_vld_reg;
        best_pos_next = best_pos_reg;
        best_mv_next  = best_mv_reg;
        best_ma_next  = best_ma_reg;
        if (usable && better)
        begin
            best_vld_next = 1'b1;
            best_pos_next = pos;
            best_mv_next  = word.mv;
            best_ma_next  = word.ma;
        end
    end

    always_comb
    begin
        res_code_next = RES_NONE;
        res_pos_next  = '0;
        res_mv_next   = '0;
        res_ma_next   = '0;
        res_mis_next  = 1'b0;
        res_word_next = '0;
        if (first_bad_next)
        begin
            res_code_next = RES_INVALID;
        end
        else if (best_vld_next)
        begin
            res_pos_next = best_pos_next;
            res_mv_next  = best_mv_next;
            res_ma_next  = need;
            if (cfg.need_mode && (best_mv_next < cfg.pref_mv))
            begin
                res_code_next = RES_FALLBACK;
                res_mis_next  = 1'b1;
            end
            else
            begin
                res_code_next = RES_MATCH;
            end
        end
        else if (five_vld_next)
        begin
            res_code_next = RES_FALLBACK;
            res_pos_next  = five_pos_next;
            res_mv_next   = SAFE_MV;
            res_ma_next   = (15'(five_ma_next) < need) ? 15'(five_ma_next) : need;
            res_mis_next  = 1'b1;
        end
        if (res_pos_next != 4'd0)
        begin
            res_word_next = {1'b0, res_pos_next[2:0], cfg.giveback, res_mis_next, 1'b1,
                             5'd0, div10_lo(res_ma_next), div10_lo(15'(cfg.rdo_max_ma))};
        end
    end

    always_comb
    begin
        res_vld_next = res_vld_reg;
        if (finish)
        begin
            res_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            res_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            first_bad_reg <= 1'b0;
            best_vld_reg  <= 1'b0;
            best_pos_reg  <= '0;
            best_mv_reg   <= '0;
            best_ma_reg   <= '0;
            five_vld_reg  <= 1'b0;
            five_pos_reg  <= '0;
            five_ma_reg   <= '0;
            res_vld_reg   <= 1'b0;
        end
        else
        begin
            res_vld_reg <= res_vld_next;
            if (finish)
            begin
                count_reg     <= '0;
                first_bad_reg <= 1'b0;
                best_vld_reg  <= 1'b0;
                best_pos_reg  <= '0;
                best_mv_reg   <= '0;
                best_ma_reg   <= '0;
                five_vld_reg  <= 1'b0;
                five_pos_reg  <= '0;
                five_ma_reg   <= '0;
            end
            else if (consume)
            begin
                count_reg     <= count_next;
                first_bad_reg <= first_bad_next;
                best_vld_reg  <= best_vld_next;
                best_pos_reg  <= best_pos_next;
                best_mv_reg   <= best_mv_next;
                best_ma_reg   <= best_ma_next;
                five_vld_reg  <= five_vld_next;
                five_pos_reg  <= five_pos_next;
                five_ma_reg   <= five_ma_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            res_code_reg <= res_code_next;
            res_pos_reg  <= res_pos_next;
            res_mv_reg   <= res_mv_next;
            res_ma_reg   <= res_ma_next;
            res_mis_reg  <= res_mis_next;
            res_word_reg <= res_word_next;
        end
    end

    assign out_valid       = res_vld_reg;
    assign result_code     = res_code_reg;
    assign chosen_position = res_pos_reg;
    assign contract_mv     = res_mv_reg;
    assign request_ma      = res_ma_reg;
    assign mismatch        = res_mis_reg;
    assign request_word    = res_word_reg;

    `PDS_ASSERT_NEXT(a_clear_after_last, clk, rst_n, finish,
        (count_reg == 4'd0) && !best_vld_reg && !five_vld_reg && !first_bad_reg)
    `PDS_ASSERT(a_best_pos_range, clk, rst_n,
        !best_vld_reg || ((best_pos_reg != 4'd0) && (best_pos_reg <= 4'(MAX_PDO_COUNT))))
    `PDS_ASSERT(a_five_pos_range, clk, rst_n, !five_vld_reg || (five_pos_reg != 4'd0))
    `PDS_ASSERT_NEXT(a_result_held, clk, rst_n, res_vld_reg && !out_ready,
        res_vld_reg && $stable(res_word_reg))
    `PDS_ASSERT(a_word_zero_without_pos, clk, rst_n,
        !res_vld_reg || (res_pos_reg != 4'd0) || (res_word_reg == 32'd0))

endmodule

FILE: hdl/pd_sink_pdo_selector_core.sv
// Top level of the USB PD sink fixed-supply PDO selector.
`timescale 1ns / 1ps

// The block takes one source-capability PDO word per beat, with the last word of the list
// marked, and emits one result beat after that last word with the chosen position, voltage,
// requested current and the encoded request word. Each beat passes an input register, a
// decode register (type, voltage and current scaling) and the tracker that updates the
// running best entry and loads the result register, so one word is accepted every cycle
// unless a last word is held back, and out_valid rises when the last word leaves the decode
// register. While a finished result waits, the words of the next list keep flowing and only
// its last word is held back. Configuration registers are written through their own
// channel, which is always ready, and must only change while no list is in flight.
module pd_sink_pdo_selector_core #(
    parameter int unsigned MAX_PDO_COUNT = pdsel_pkg::MAX_PDOS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] raw_pdo,
    input  logic        last_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_code,
    output logic [3:0]  chosen_position,
    output logic [15:0] contract_mv,
    output logic [14:0] request_ma,
    output logic        mismatch,
    output logic [31:0] request_word
);
    import pdsel_pkg::*;

    pdsel_cfg_t  cfg;
    pdsel_word_t word;
    logic        take;

    pdsel_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pdsel_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .raw_pdo   (raw_pdo),
        .last_item (last_item),
        .take      (take),
        .word      (word)
    );

    pdsel_track #(
        .MAX_PDO_COUNT (MAX_PDO_COUNT)
    ) u_track (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .word            (word),
        .take            (take),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_code     (result_code),
        .chosen_position (chosen_position),
        .contract_mv     (contract_mv),
        .request_ma      (request_ma),
        .mismatch        (mismatch),
        .request_word    (request_word)
    );

endmodule
